/* sv/krs_pkg.sv */
package krs_pkg;

  localparam int unsigned CAPACITY   = 8;
  localparam int unsigned PLATE_BITS = 24;

  localparam int unsigned PLATE_W = 24;
  localparam int unsigned OCC_W   = 4;
  localparam int unsigned ENTRY_W = (PLATE_BITS < PLATE_W) ? PLATE_BITS : PLATE_W;
  localparam int unsigned ADDR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W   = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W   = CNT_W + 1;

  localparam logic [1:0] ActPark     = 2'd0;
  localparam logic [1:0] ActRetrieve = 2'd1;
  localparam logic [1:0] ActList     = 2'd2;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StFull     = 2'd1;
  localparam logic [1:0] StEmpty    = 2'd2;
  localparam logic [1:0] StNotFound = 2'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic [PLATE_W-1:0] plate;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [PLATE_W-1:0] plate_out;
    logic [OCC_W-1:0]   occupancy;
    logic               last;
  } out_t;

  typedef enum logic [4:0] {
    FsmIdle   = 5'b00001,
    FsmSearch = 5'b00010,
    FsmShift  = 5'b00100,
    FsmList   = 5'b01000,
    FsmEmit   = 5'b10000
  } fsm_e;

endpackage

/* sv/keyed_removal_stack.sv */
// Park and empty cases: the result is registered from the Emit state; action 3 is
// accepted and gives no result.
// Retrieve: entries are searched from the top down, then on a hit each entry above
// it is moved down one place, then the result follows.
// List: top entry first, one result a cycle while the output is not stalled.
// One item at a time; the RAM's single read port sets the pace.
// Reset clears the count, state machine and output valid flag; RAM is not cleared.
module keyed_removal_stack (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  krs_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output krs_pkg::out_t  out_data_o
);
  import krs_pkg::*;

  fsm_e               state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [ADDR_W-1:0]  pos_q, pos_d;
  logic [ENTRY_W-1:0] key_q, key_d;
  logic [1:0]         res_q, res_d;
  logic               out_valid_q, out_valid_d;
  out_t               out_q, out_d;

  logic               we, re;
  logic [ADDR_W-1:0]  waddr, raddr;
  logic [ENTRY_W-1:0] wdata, rdata;
  logic               slot_free, in_fire;
  logic [IDX_W-1:0]   pos_x, cnt_x;

  krs_ram #(
    .Width (ENTRY_W),
    .Depth (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign in_ready_o  = (state_q == FsmIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign pos_x       = IDX_W'(pos_q);
  assign cnt_x       = IDX_W'(count_q);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    key_d       = key_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    we          = 1'b0;
    waddr       = pos_q;
    wdata       = rdata;
    re          = 1'b0;
    raddr       = pos_q;

    case (state_q)
      FsmIdle: begin
        if (in_fire) begin
          key_d = in_data_i.plate[ENTRY_W-1:0];
          pos_d = ADDR_W'(cnt_x - IDX_W'(1));
          raddr = ADDR_W'(cnt_x - IDX_W'(1));
          case (in_data_i.action)
            ActPark: begin
              state_d = FsmEmit;
              if (cnt_x >= IDX_W'(CAPACITY)) begin
                res_d = StFull;
              end else begin
                res_d   = StOk;
                we      = 1'b1;
                waddr   = ADDR_W'(count_q);
                wdata   = in_data_i.plate[ENTRY_W-1:0];
                count_d = CNT_W'(cnt_x + IDX_W'(1));
              end
            end
            ActRetrieve, ActList: begin
              if (count_q == '0) begin
                res_d   = StEmpty;
                state_d = FsmEmit;
              end else begin
                re      = 1'b1;
                state_d = (in_data_i.action == ActList) ? FsmList : FsmSearch;
              end
            end
            default: ;
          endcase
        end
      end

      FsmSearch: begin
        if (rdata == key_q) begin
          if (pos_x + IDX_W'(1) < cnt_x) begin
            re      = 1'b1;
            raddr   = ADDR_W'(pos_x + IDX_W'(1));
            state_d = FsmShift;
          end else begin
            count_d = CNT_W'(cnt_x - IDX_W'(1));
            res_d   = StOk;
            state_d = FsmEmit;
          end
        end else if (pos_q == '0) begin
          res_d   = StNotFound;
          state_d = FsmEmit;
        end else begin
          re      = 1'b1;
          raddr   = ADDR_W'(pos_x - IDX_W'(1));
          pos_d   = ADDR_W'(pos_x - IDX_W'(1));
        end
      end

      FsmShift: begin
        // move entry pos+1 down to pos, fetch the next one ahead
        we    = 1'b1;
        waddr = pos_q;
        wdata = rdata;
        pos_d = ADDR_W'(pos_x + IDX_W'(1));
        if (pos_x + IDX_W'(2) < cnt_x) begin
          re    = 1'b1;
          raddr = ADDR_W'(pos_x + IDX_W'(2));
        end else begin
          count_d = CNT_W'(cnt_x - IDX_W'(1));
          res_d   = StOk;
          state_d = FsmEmit;
        end
      end

      FsmList: begin
        if (slot_free) begin
          out_valid_d     = 1'b1;
          out_d.status    = StOk;
          out_d.plate_out = PLATE_W'(rdata);
          out_d.occupancy = OCC_W'(count_q);
          out_d.last      = (pos_q == '0);
          if (pos_q == '0) begin
            state_d = FsmIdle;
          end else begin
            re    = 1'b1;
            raddr = ADDR_W'(pos_x - IDX_W'(1));
            pos_d = ADDR_W'(pos_x - IDX_W'(1));
          end
        end
      end

      FsmEmit: begin
        if (slot_free) begin
          out_valid_d     = 1'b1;
          out_d.status    = res_q;
          out_d.plate_out = '0;
          out_d.occupancy = OCC_W'(count_q);
          out_d.last      = 1'b1;
          state_d         = FsmIdle;
        end
      end

      default: state_d = FsmIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FsmIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    key_q <= key_d;
    res_q <= res_d;
    out_q <= out_d;
  end

endmodule

/* sv/krs_ram.sv */
module krs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sim/tb_keyed_removal_stack.sv */
module tb_keyed_removal_stack;
  import krs_pkg::*;

  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned HOLD_AT     = 60;
  localparam int unsigned HOLD_CYCLES = 120;
  localparam int unsigned RAND_ITEMS  = 85;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam logic [1:0]  ActUnused   = 2'd3;

  class stack_scoreboard;
    logic [PLATE_W-1:0] slot [CAPACITY];
    int unsigned fill;
    out_t pending_q[$];
    int unsigned errors, n_in, n_out, n_full, n_empty, n_miss;

    function new();
      fill = 0;
      errors = 0;
      n_in = 0;
      n_out = 0;
      n_full = 0;
      n_empty = 0;
      n_miss = 0;
    endfunction

    task report(string what);
      errors++;
      $display("mismatch at %0t: %s", $realtime, what);
    endtask

    function logic [PLATE_W-1:0] key_of(logic [PLATE_W-1:0] p);
      logic [PLATE_W-1:0] m;
      for (int b = 0; b < PLATE_W; b++) m[b] = (b < PLATE_BITS);
      return p & m;
    endfunction

    function void push_res(logic [1:0] st, logic [PLATE_W-1:0] pl, logic fin);
      out_t r;
      r.status    = st;
      r.plate_out = pl;
      r.occupancy = OCC_W'(fill);
      r.last      = fin;
      pending_q.push_back(r);
    endfunction

    function void note_transfer(in_t it);
      logic [PLATE_W-1:0] k;
      int pos;
      int unsigned j;
      k = key_of(it.plate);
      n_in++;
      case (it.action)
        ActPark: begin
          if (fill >= CAPACITY) begin
            n_full++;
            push_res(StFull, '0, 1'b1);
          end else begin
            slot[fill] = k;
            fill++;
            push_res(StOk, '0, 1'b1);
          end
        end
        ActRetrieve: begin
          if (fill == 0) begin
            n_empty++;
            push_res(StEmpty, '0, 1'b1);
          end else begin
            pos = int'(fill) - 1;
            while (pos >= 0 && slot[pos] != k) pos--;
            if (pos < 0) begin
              n_miss++;
              push_res(StNotFound, '0, 1'b1);
            end else begin
              // entries above the hit drop one place
              for (j = pos; j + 1 < fill; j++) slot[j] = slot[j+1];
              fill--;
              push_res(StOk, '0, 1'b1);
            end
          end
        end
        ActList: begin
          if (fill == 0) begin
            n_empty++;
            push_res(StEmpty, '0, 1'b1);
          end else begin
            for (pos = int'(fill) - 1; pos >= 0; pos--) push_res(StOk, slot[pos], pos == 0);
          end
        end
        default: ;
      endcase
    endfunction

    task check_result(out_t got);
      out_t e;
      n_out++;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result st=%0d plate=%h occ=%0d last=%0d",
                         got.status, got.plate_out, got.occupancy, got.last));
        return;
      end
      e = pending_q.pop_front();
      if (got.status !== e.status)
        report($sformatf("status %0d, want %0d", got.status, e.status));
      if (got.plate_out !== e.plate_out)
        report($sformatf("plate_out %h, want %h", got.plate_out, e.plate_out));
      if (got.occupancy !== e.occupancy)
        report($sformatf("occupancy %0d, want %0d", got.occupancy, e.occupancy));
      if (got.last !== e.last)
        report($sformatf("last %0d, want %0d", got.last, e.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  stack_scoreboard sb;
  int unsigned n_sent = 0;
  int unsigned n_taken = 0;
  int unsigned idle_cycles = 0;

  always #5 clk = ~clk;

  keyed_removal_stack dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  function automatic in_t mk(logic [1:0] a, logic [PLATE_W-1:0] p);
    in_t it;
    it.action = a;
    it.plate  = p;
    return it;
  endfunction

  function automatic int unsigned send_gap();
    if ((n_sent / 16) % 3 == 2) return 0;
    return $urandom_range(0, 8);
  endfunction

  task automatic send_item(in_t it);
    int unsigned gap;
    gap = send_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_transfer(it);
    n_sent++;
  endtask

  task automatic send_random();
    int unsigned r, park_lim, ret_lim;
    logic [PLATE_W-1:0] p;
    logic [PLATE_W-1:0] few [4];
    few = '{24'h000000, 24'hFFFFFF, 24'h00C0DE, 24'h5A5A5A};
    if ((n_sent / 20) % 2 == 0) begin
      park_lim = 55;
      ret_lim  = 80;
    end else begin
      park_lim = 20;
      ret_lim  = 80;
    end
    r = $urandom_range(0, 99);
    p = PLATE_W'($urandom());
    if (r < park_lim) begin
      if ($urandom_range(0, 3) == 0) p = few[$urandom_range(0, 3)];
      send_item(mk(ActPark, p));
    end else if (r < ret_lim) begin
      if (sb.fill != 0 && $urandom_range(0, 3) != 0) p = sb.slot[$urandom_range(0, sb.fill - 1)];
      send_item(mk(ActRetrieve, p));
    end else if (r < 95) begin
      send_item(mk(ActList, p));
    end else begin
      send_item(mk(ActUnused, p));
    end
  endtask

  initial begin
    int unsigned gap;
    wait (rst_n);
    forever begin
      @(negedge clk);
      gap = ((n_taken / 24) % 3 == 1) ? 0 : $urandom_range(0, 8);
      // long stall so the block backs up into its input
      if (n_taken == HOLD_AT) gap = HOLD_CYCLES;
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_data);
      n_taken++;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    send_item(mk(ActList,     24'h000000));
    send_item(mk(ActRetrieve, 24'h000005));
    send_item(mk(ActUnused,   24'h000000));
    send_item(mk(ActPark,     24'h000000));
    send_item(mk(ActPark,     24'hFFFFFF));
    send_item(mk(ActPark,     24'h123456));
    send_item(mk(ActPark,     24'hFFFFFF));
    send_item(mk(ActRetrieve, 24'h777777));
    send_item(mk(ActList,     24'hFFFFFF));
    send_item(mk(ActRetrieve, 24'hFFFFFF));
    send_item(mk(ActList,     24'h000000));
    send_item(mk(ActRetrieve, 24'h000000));
    send_item(mk(ActPark,     24'hAAAAAA));
    send_item(mk(ActPark,     24'h555555));
    send_item(mk(ActPark,     24'h000001));
    send_item(mk(ActPark,     24'h800000));
    send_item(mk(ActPark,     24'h7FFFFF));
    send_item(mk(ActPark,     24'h0F0F0F));
    send_item(mk(ActPark,     24'h424242));
    send_item(mk(ActList,     24'h000000));
    send_item(mk(ActRetrieve, 24'h800000));
    send_item(mk(ActUnused,   24'hFFFFFF));
    send_item(mk(ActRetrieve, 24'h0F0F0F));
    send_item(mk(ActPark,     24'h000000));
    send_item(mk(ActList,     24'h000000));

    repeat (RAND_ITEMS) send_random();

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d input transfers and %0d result transfers, with a long output stall",
             sb.n_in, sb.n_out);
    $display("full pushes %0d, empty requests %0d, retrieve misses %0d",
             sb.n_full, sb.n_empty, sb.n_miss);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* keyed_removal_stack.f */
sv/krs_pkg.sv
sv/krs_ram.sv
sv/keyed_removal_stack.sv
sim/tb_keyed_removal_stack.sv
